FILE: design/ray_brick_dda_first_hit_assert.svh
// Assertion macros of the ray brick traversal sequencer.
`ifndef RAY_BRICK_DDA_FIRST_HIT_ASSERT_SVH
`define RAY_BRICK_DDA_FIRST_HIT_ASSERT_SVH

// The consequent must hold in the clock after the antecedent.
`define RBDDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rbdda: next-cycle check failed");

// The consequent must hold in the same cycle as the antecedent.
`define RBDDA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rbdda: same-cycle check failed");

`endif

FILE: design/rbdda_pkg.sv
// Package with types, constants and helpers of the ray brick traversal block.
package rbdda_pkg;

    localparam int BRICK_SIDE_DEF = 4;
    localparam int AXES           = 3;
    localparam int CRD_W          = 4;
    localparam int DIV_STEPS      = 33;
    localparam int CNT_W          = 6;
    localparam int SAT_W          = 67;

    localparam logic [30:0] CFG_RESET_VAL     = 31'd65536;
    localparam logic        CFG_CELL_SIZE     = 1'b0;
    localparam logic        CFG_INV_CELL_SIZE = 1'b1;

    localparam logic [32:0] RECIP_NUM = 33'h1_0000_0000;

    typedef logic signed [31:0]      t_q;
    typedef logic signed [CRD_W-1:0] t_crd;

    localparam t_q Q_MAX = 32'sh7FFF_FFFF;
    localparam t_q Q_MIN = 32'sh8000_0000;

    // Multiplier operations.
    typedef enum logic [2:0] {
        MOP_T0,
        MOP_T1,
        MOP_DT,
        MOP_CRD,
        MOP_TDEL
    } t_mop;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_RCP,
        ST_MUL1,
        ST_SLAB_WB,
        ST_TIN,
        ST_SLAB_TEST,
        ST_MUL2,
        ST_ENT_WB,
        ST_OFS,
        ST_TCUR,
        ST_WALK
    } t_state;

    typedef struct packed {
        logic       load;
        logic       div_step;
        logic       rcp_load;
        logic       mop_valid;
        t_mop       mop;
        logic [1:0] axis;
        logic       tin_load;
        logic       ofs_load;
        logic       tcur_load;
        logic       walk_step;
        logic       res_load;
        logic       res_hit;
    } t_cmd;

    typedef struct packed {
        logic slab_ok;
        logic walk_out;
        logic walk_hit;
    } t_sts;

    // Saturate a wide signed value to the signed 32-bit range.
    function automatic t_q sat32(input logic signed [SAT_W-1:0] v);
        t_q res;
        if (v > SAT_W'(Q_MAX)) begin
            res = Q_MAX;
        end else if (v < SAT_W'(Q_MIN)) begin
            res = Q_MIN;
        end else begin
            res = t_q'(v);
        end
        return res;
    endfunction

endpackage

FILE: design/rbdda_ctrl.sv
// Sequencer that steps the traversal datapath through one ray.
`include "ray_brick_dda_first_hit_assert.svh"

module rbdda_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  rbdda_pkg::t_sts i_sts,
    output rbdda_pkg::t_cmd o_cmd
);
    import rbdda_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [1:0]       w_axis;

    // Axis of the current multiplier operation follows the counter modulo three.
    always_comb begin
        if (r_cnt < CNT_W'(3)) begin
            w_axis = 2'(r_cnt);
        end else if (r_cnt < CNT_W'(6)) begin
            w_axis = 2'(r_cnt - CNT_W'(3));
        end else begin
            w_axis = 2'(r_cnt - CNT_W'(6));
        end
    end

    // State and counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.mop  = MOP_T0;
        o_cmd.axis = w_axis;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_RCP;
                end
            end
            ST_RCP: begin
                o_cmd.rcp_load = 1'b1;
                n_cnt          = '0;
                n_state        = ST_MUL1;
            end
            ST_MUL1: begin
                o_cmd.mop_valid = 1'b1;
                o_cmd.mop       = (r_cnt < CNT_W'(3)) ? MOP_T0 : MOP_T1;
                n_cnt           = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(5)) begin
                    n_state = ST_SLAB_WB;
                end
            end
            ST_SLAB_WB: begin
                n_state = ST_TIN;
            end
            ST_TIN: begin
                o_cmd.tin_load = 1'b1;
                n_state        = ST_SLAB_TEST;
            end
            ST_SLAB_TEST: begin
                n_cnt = '0;
                if (!i_sts.slab_ok) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = ST_IDLE;
                end else begin
                    n_state = ST_MUL2;
                end
            end
            ST_MUL2: begin
                o_cmd.mop_valid = 1'b1;
                if (r_cnt < CNT_W'(3)) begin
                    o_cmd.mop = MOP_DT;
                end else if (r_cnt < CNT_W'(6)) begin
                    o_cmd.mop = MOP_CRD;
                end else begin
                    o_cmd.mop = MOP_TDEL;
                end
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(8)) begin
                    n_state = ST_ENT_WB;
                end
            end
            ST_ENT_WB: begin
                n_state = ST_OFS;
            end
            ST_OFS: begin
                o_cmd.ofs_load = 1'b1;
                n_state        = ST_TCUR;
            end
            ST_TCUR: begin
                o_cmd.tcur_load = 1'b1;
                n_state         = ST_WALK;
            end
            ST_WALK: begin
                if (i_sts.walk_out) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = ST_IDLE;
                end else if (i_sts.walk_hit) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_hit  = 1'b1;
                    n_state        = ST_IDLE;
                end else begin
                    o_cmd.walk_step = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy = (r_state != ST_IDLE);

    // A transfer in always starts the reciprocal divide.
    `RBDDA_ASSERT_NEXT(a_start_div, i_clk, i_rst_n, start && !busy, r_state == ST_DIV)
    // Every result returns the sequencer to idle.
    `RBDDA_ASSERT_NEXT(a_res_idle, i_clk, i_rst_n, o_cmd.res_load, r_state == ST_IDLE)
    // Leaving the brick during the walk always reports a miss.
    `RBDDA_ASSERT_SAME(a_out_miss, i_clk, i_rst_n,
        (r_state == ST_WALK) && i_sts.walk_out, o_cmd.res_load && !o_cmd.res_hit)

endmodule

FILE: design/rbdda_dp.sv
// Datapath: reciprocal divider lanes, shared multiplier, entry setup and DDA step.
module rbdda_dp #(
    parameter int BRICK_SIDE = rbdda_pkg::BRICK_SIDE_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rbdda_pkg::t_cmd    i_cmd,
    output rbdda_pkg::t_sts    o_sts,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [30:0]        i_cfg_data,
    input  rbdda_pkg::t_q      i_dir_x,
    input  rbdda_pkg::t_q      i_dir_y,
    input  rbdda_pkg::t_q      i_dir_z,
    input  rbdda_pkg::t_q      i_lo_corner_x,
    input  rbdda_pkg::t_q      i_lo_corner_y,
    input  rbdda_pkg::t_q      i_lo_corner_z,
    input  rbdda_pkg::t_q      i_hi_corner_x,
    input  rbdda_pkg::t_q      i_hi_corner_y,
    input  rbdda_pkg::t_q      i_hi_corner_z,
    input  logic [63:0]        i_occupancy_mask,
    output logic               o_valid,
    output logic               o_hit,
    output logic [5:0]         o_cell_index
);
    import rbdda_pkg::*;

    localparam int   CW      = (BRICK_SIDE > 2) ? $clog2(BRICK_SIDE) : 1;
    localparam int   SS      = BRICK_SIDE * BRICK_SIDE;
    localparam t_crd CRD_MAX = t_crd'(BRICK_SIDE - 1);

    // Configuration and control registers.
    logic [30:0] r_cell_size, r_inv_cell;
    logic        r_valid, r_wb_valid;

    // Payload registers.
    t_q                 r_dir[AXES], r_lo[AXES], r_hi[AXES];
    logic [63:0]        r_mask;
    logic [32:0]        r_num;
    logic [32:0]        r_rem[AXES], r_quo[AXES];
    t_q                 r_rc[AXES], r_t0[AXES], r_tmn[AXES], r_tmx[AXES];
    t_q                 r_tin, r_tout;
    t_q                 r_diff[AXES], r_tdel[AXES], r_ofs[AXES], r_tcur[AXES];
    t_crd               r_crd[AXES];
    logic signed [65:0] r_prod;
    t_mop               r_wb_mop;
    logic [1:0]         r_wb_axis;
    logic               r_hit;
    logic [5:0]         r_idx;

    // Combinational values.
    logic [32:0]        n_rem[AXES];
    logic               w_qbit[AXES];
    t_q                 n_rc[AXES];
    logic signed [32:0] w_opa, w_opb;
    t_q                 w_q16;
    logic signed [65:0] w_crs;
    t_crd               w_crd_clamp;
    t_q                 w_tin, w_tout;
    t_q                 n_ofs[AXES], n_tcur[AXES], w_next[AXES];
    logic               w_sx, w_syx;
    t_crd               w_step[AXES];
    logic               w_out;
    logic [5:0]         w_id;

    // Radix-2 restoring divide of 2^32 by |dir|, one lane per axis, and the
    // signed, saturated reciprocal that follows.
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            logic signed [32:0] dext;
            logic [32:0]        dabs, shifted;
            logic signed [33:0] qs;
            dext    = 33'(r_dir[a]);
            dabs    = (dext < 0) ? 33'(-dext) : 33'(dext);
            shifted = {r_rem[a][31:0], r_num[32]};
            w_qbit[a] = (shifted >= dabs);
            n_rem[a]  = w_qbit[a] ? (shifted - dabs) : shifted;
            qs = r_dir[a][31] ? -$signed({1'b0, r_quo[a]}) : $signed({1'b0, r_quo[a]});
            n_rc[a] = (r_dir[a] == '0) ? Q_MAX : sat32(SAT_W'(qs));
        end
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        logic signed [32:0] arc;
        arc = (r_rc[i_cmd.axis] < 0) ? -33'(r_rc[i_cmd.axis]) : 33'(r_rc[i_cmd.axis]);
        case (i_cmd.mop)
            MOP_T0: begin
                w_opa = 33'(r_lo[i_cmd.axis]);
                w_opb = 33'(r_rc[i_cmd.axis]);
            end
            MOP_T1: begin
                w_opa = 33'(r_hi[i_cmd.axis]);
                w_opb = 33'(r_rc[i_cmd.axis]);
            end
            MOP_DT: begin
                w_opa = 33'(r_dir[i_cmd.axis]);
                w_opb = 33'(r_tin);
            end
            MOP_CRD: begin
                w_opa = 33'(r_diff[i_cmd.axis]);
                w_opb = $signed({2'b00, r_inv_cell});
            end
            MOP_TDEL: begin
                w_opa = $signed({2'b00, r_cell_size});
                w_opb = arc;
            end
            default: begin
                w_opa = '0;
                w_opb = '0;
            end
        endcase
    end

    // Post-processing of the registered product.
    always_comb begin
        w_q16 = sat32(SAT_W'(r_prod >>> 16));
        w_crs = r_prod >>> 32;
        if (w_crs < 0) begin
            w_crd_clamp = '0;
        end else if (w_crs > 66'(BRICK_SIDE - 1)) begin
            w_crd_clamp = CRD_MAX;
        end else begin
            w_crd_clamp = t_crd'(w_crs);
        end
    end

    // Slab entry and exit times.
    always_comb begin
        w_tin  = r_tmn[0];
        w_tout = r_tmx[0];
        for (int a = 1; a < AXES; a++) begin
            if (r_tmn[a] > w_tin) begin
                w_tin = r_tmn[a];
            end
            if (r_tmx[a] < w_tout) begin
                w_tout = r_tmx[a];
            end
        end
    end

    // Starting crossing offsets and times of each axis.
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            t_q opos, oneg;
            opos = sat32(SAT_W'(r_tdel[a]) * SAT_W'(r_crd[a]));
            oneg = sat32(SAT_W'(r_tdel[a]) * SAT_W'(BRICK_SIDE - 1) - SAT_W'(opos));
            n_ofs[a]  = r_dir[a][31] ? oneg : opos;
            n_tcur[a] = sat32(SAT_W'(r_tmn[a]) + SAT_W'(r_ofs[a]));
        end
    end

    // One DDA step: next crossing per axis and the axis tie rule.
    always_comb begin
        w_out = 1'b0;
        for (int a = 0; a < AXES; a++) begin
            w_next[a] = sat32(SAT_W'(r_tcur[a]) + SAT_W'(r_tdel[a]));
            w_step[a] = r_dir[a][31] ? (r_crd[a] - t_crd'(1)) : (r_crd[a] + t_crd'(1));
            if ((r_crd[a] < 0) || (r_crd[a] > CRD_MAX)) begin
                w_out = 1'b1;
            end
        end
        w_sx  = (w_next[0] < w_next[1]) && (w_next[0] < w_next[2]);
        w_syx = (w_next[1] < w_next[2]);
        w_id  = 6'(r_crd[2][CW-1:0]) * 6'(SS) + 6'(r_crd[1][CW-1:0]) * 6'(BRICK_SIDE)
              + 6'(r_crd[0][CW-1:0]);
    end

    assign o_sts.slab_ok  = (r_tin > 0) && (r_tin < r_tout);
    assign o_sts.walk_out = w_out;
    assign o_sts.walk_hit = r_mask[w_id];

    // Configuration and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_size <= CFG_RESET_VAL;
            r_inv_cell  <= CFG_RESET_VAL;
            r_valid     <= 1'b0;
            r_wb_valid  <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_idx == CFG_CELL_SIZE)) begin
                r_cell_size <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_idx == CFG_INV_CELL_SIZE)) begin
                r_inv_cell <= i_cfg_data;
            end
            r_valid    <= i_cmd.res_load;
            r_wb_valid <= i_cmd.mop_valid;
        end
    end

    // Input capture and divider lanes.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dir[0] <= i_dir_x;
            r_dir[1] <= i_dir_y;
            r_dir[2] <= i_dir_z;
            r_lo[0]  <= i_lo_corner_x;
            r_lo[1]  <= i_lo_corner_y;
            r_lo[2]  <= i_lo_corner_z;
            r_hi[0]  <= i_hi_corner_x;
            r_hi[1]  <= i_hi_corner_y;
            r_hi[2]  <= i_hi_corner_z;
            r_mask   <= i_occupancy_mask;
            r_num    <= RECIP_NUM;
            for (int a = 0; a < AXES; a++) begin
                r_rem[a] <= '0;
                r_quo[a] <= '0;
            end
        end else if (i_cmd.div_step) begin
            r_num <= {r_num[31:0], 1'b0};
            for (int a = 0; a < AXES; a++) begin
                r_rem[a] <= n_rem[a];
                r_quo[a] <= {r_quo[a][31:0], w_qbit[a]};
            end
        end
        if (i_cmd.rcp_load) begin
            for (int a = 0; a < AXES; a++) begin
                r_rc[a] <= n_rc[a];
            end
        end
    end

    // Shared multiplier, registered, with write-back from the registered product in the following cycle.
    always_ff @(posedge i_clk) begin
        r_prod    <= w_opa * w_opb;
        r_wb_mop  <= i_cmd.mop;
        r_wb_axis <= i_cmd.axis;
        if (r_wb_valid) begin
            case (r_wb_mop)
                MOP_T0: begin
                    r_t0[r_wb_axis] <= w_q16;
                end
                MOP_T1: begin
                    r_tmn[r_wb_axis] <= (r_t0[r_wb_axis] < w_q16) ? r_t0[r_wb_axis] : w_q16;
                    r_tmx[r_wb_axis] <= (r_t0[r_wb_axis] < w_q16) ? w_q16 : r_t0[r_wb_axis];
                end
                MOP_DT: begin
                    r_diff[r_wb_axis] <= sat32(SAT_W'(w_q16) - SAT_W'(r_lo[r_wb_axis]));
                end
                MOP_CRD: begin
                    r_crd[r_wb_axis] <= w_crd_clamp;
                end
                MOP_TDEL: begin
                    r_tdel[r_wb_axis] <= w_q16;
                end
                default: begin
                    r_t0[r_wb_axis] <= r_t0[r_wb_axis];
                end
            endcase
        end else if (i_cmd.walk_step) begin
            // Advance the axis chosen by the tie rule.
            if (w_sx) begin
                r_tcur[0] <= w_next[0];
                r_crd[0]  <= w_step[0];
            end else if (w_syx) begin
                r_tcur[1] <= w_next[1];
                r_crd[1]  <= w_step[1];
            end else begin
                r_tcur[2] <= w_next[2];
                r_crd[2]  <= w_step[2];
            end
        end else if (i_cmd.tcur_load) begin
            for (int a = 0; a < AXES; a++) begin
                r_tcur[a] <= n_tcur[a];
            end
        end
        if (i_cmd.tin_load) begin
            r_tin  <= w_tin;
            r_tout <= w_tout;
        end
        if (i_cmd.ofs_load) begin
            for (int a = 0; a < AXES; a++) begin
                r_ofs[a] <= n_ofs[a];
            end
        end
        if (i_cmd.res_load) begin
            r_hit <= i_cmd.res_hit;
            r_idx <= i_cmd.res_hit ? w_id : 6'd0;
        end
    end

    assign o_valid      = r_valid;
    assign o_hit        = r_hit;
    assign o_cell_index = r_idx;

endmodule

FILE: design/ray_brick_dda_first_hit.sv
// Top level of the first-hit voxel traversal of one brick.
// One ray is taken when start is high and busy is low. The result comes back
// on o_hit and o_cell_index for exactly one cycle with o_valid high, and the
// receiver cannot stall it. A ray that misses the brick in the slab test
// returns without a walk; a ray that enters returns when the walk reaches an
// occupied cell or leaves the brick. The return time is set by the 33-step
// radix-2 reciprocal divide, the fifteen operations issued in turn to the
// single shared multiplier and the one-cell-per-cycle walk. busy drops in
// the cycle that o_valid is high, so the next ray may be started then.
// Configuration writes take effect at once and belong to times when the
// block is idle.
module ray_brick_dda_first_hit #(
    parameter int BRICK_SIDE = rbdda_pkg::BRICK_SIDE_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [30:0]   i_cfg_data,
    input  rbdda_pkg::t_q i_dir_x,
    input  rbdda_pkg::t_q i_dir_y,
    input  rbdda_pkg::t_q i_dir_z,
    input  rbdda_pkg::t_q i_lo_corner_x,
    input  rbdda_pkg::t_q i_lo_corner_y,
    input  rbdda_pkg::t_q i_lo_corner_z,
    input  rbdda_pkg::t_q i_hi_corner_x,
    input  rbdda_pkg::t_q i_hi_corner_y,
    input  rbdda_pkg::t_q i_hi_corner_z,
    input  logic [63:0]   i_occupancy_mask,
    output logic          o_valid,
    output logic          o_hit,
    output logic [5:0]    o_cell_index
);
    import rbdda_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // Sequencer.
    rbdda_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // Arithmetic and walk datapath.
    rbdda_dp #(
        .BRICK_SIDE (BRICK_SIDE)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_dir_x          (i_dir_x),
        .i_dir_y          (i_dir_y),
        .i_dir_z          (i_dir_z),
        .i_lo_corner_x    (i_lo_corner_x),
        .i_lo_corner_y    (i_lo_corner_y),
        .i_lo_corner_z    (i_lo_corner_z),
        .i_hi_corner_x    (i_hi_corner_x),
        .i_hi_corner_y    (i_hi_corner_y),
        .i_hi_corner_z    (i_hi_corner_z),
        .i_occupancy_mask (i_occupancy_mask),
        .o_valid          (o_valid),
        .o_hit            (o_hit),
        .o_cell_index     (o_cell_index)
    );

endmodule
